// ===== rtl/llcb_pkg.sv =====
// Shared types and constants for the last-lines capture buffer.
package llcb_pkg;

  // Text constants
  localparam logic [7:0] NEWLINE_CHAR = 8'd10;

  // Configuration register width and reset value
  localparam int unsigned CNT_W = 4;
  localparam logic [CNT_W-1:0] LINE_COUNT_RST = 4'd10;

  // Depth of the result queue ahead of the output port
  localparam int unsigned RES_DEPTH = 3;
  localparam int unsigned RES_PTR_W = 2;
  localparam int unsigned RES_CNT_W = 2;

  // Item kind carried on the input tuser bit
  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } llcb_op_t;

  // One result item
  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
    logic       trunc;
  } llcb_result_t;

endpackage

// ===== rtl/llcb_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module llcb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1280,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/llcb_out_fifo.sv =====
// Small result queue that decouples the read pipeline from the output port.
module llcb_out_fifo (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               push,
  input  llcb_pkg::llcb_result_t             push_data,
  output logic [llcb_pkg::RES_CNT_W-1:0]     count,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output llcb_pkg::llcb_result_t             out_data
);
  import llcb_pkg::*;

  llcb_result_t               slot_r [RES_DEPTH];
  logic [RES_PTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [RES_PTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [RES_CNT_W-1:0]       count_r, count_nxt;
  logic                       pop;

  function automatic logic [RES_PTR_W-1:0] ptr_inc(input logic [RES_PTR_W-1:0] p);
    logic [RES_PTR_W-1:0] r;
    r = (p == RES_PTR_W'(RES_DEPTH - 1)) ? '0 : p + 1'b1;
    return r;
  endfunction

  assign pop        = out_tvalid && out_tready;
  assign out_tvalid = (count_r != '0);
  assign out_data   = slot_r[rd_ptr_r];
  assign count      = count_r;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store pushed results
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/last_lines_capture_buffer.sv =====
// Top level of the last-lines capture buffer.
//
// Usage: the input stream carries one item per transfer. in_tuser selects the
// kind: a write brings one text byte on in_tdata, a read asks for the next
// kept byte. Writes gather bytes into lines held in a ring of line slots in
// one byte RAM; only the last line_count complete lines stay. A line that
// reaches LINE_BYTES-1 bytes is cut to LINE_BYTES-2 bytes plus a newline and
// the rest of it is dropped. A read first commits a pending unterminated line
// and then returns one byte, oldest line first, as one output transfer.
// Writes produce no output transfer.
// Throughput: one item per cycle while in_tready is high; each item is at most
// one RAM access plus a pointer update, and line lengths sit in flops so the
// read pointer advances at once. Read path: a read's result passes the RAM
// read register, then the result queue, before it is offered on out_tvalid.
// Stalls: a three-entry result queue absorbs results while out_tready is low;
// in_tready drops only when the queue plus the read in flight fill it.
// Reset: the ring is empty, line_count is 10, the truncation flag is clear.
// A write on cfg_wr_en sets line_count and empties the ring.
module last_lines_capture_buffer #(
  parameter int unsigned MAX_LINES  = 15,
  parameter int unsigned LINE_BYTES = 80
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_wr_en,
  input  logic [llcb_pkg::CNT_W-1:0]    cfg_wr_data,   // line_count
  // input stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,      // [7:0] in_byte
  input  logic [0:0]                    in_tuser,      // [0] operation
  // result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [7:0]                    out_tdata,     // [7:0] out_byte
  output logic [1:0]                    out_tuser,     // [0] out_valid, [1] truncated
  output logic                          out_tlast      // last_byte
);
  import llcb_pkg::*;

  localparam int unsigned SLOTS  = MAX_LINES + 1;
  localparam int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned POS_W  = $clog2(LINE_BYTES);
  localparam int unsigned DEPTH  = SLOTS * LINE_BYTES;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam logic [ADDR_W-1:0] LB_A    = ADDR_W'(LINE_BYTES);
  localparam logic [POS_W-1:0]  CUT_POS = POS_W'(LINE_BYTES - 2);

  // Control state
  logic [CNT_W-1:0]  line_count_r, line_count_nxt;
  logic [SLOT_W-1:0] oldest_r, oldest_nxt;
  logic [SLOT_W-1:0] fill_r, fill_nxt;
  logic [POS_W-1:0]  fill_pos_r, fill_pos_nxt;
  logic [POS_W-1:0]  read_pos_r, read_pos_nxt;
  logic              skip_r, skip_nxt;
  logic              cut_r, cut_nxt;

  // Per-slot line lengths
  logic [POS_W-1:0]  len_r [SLOTS];

  // Read stage between RAM and result queue
  logic              s1_v_r, s1_v_nxt;
  logic              s1_valid_r, s1_valid_nxt;
  logic              s1_last_r, s1_last_nxt;
  logic              s1_trunc_r, s1_trunc_nxt;

  // Datapath
  logic                  accept;
  llcb_op_t              op;
  logic [SLOT_W-1:0]     last_idx;
  logic                  do_commit;
  logic [POS_W-1:0]      commit_len;
  logic [SLOT_W-1:0]     oldest_c, fill_c;
  logic [POS_W-1:0]      rpos_c;
  logic [POS_W-1:0]      cur_len;
  logic [POS_W:0]        rpos_inc;
  logic                  ram_we, ram_re;
  logic [ADDR_W-1:0]     ram_waddr, ram_raddr;
  logic [7:0]            ram_wdata, ram_rdata;
  logic [RES_CNT_W-1:0]  q_count;
  logic [RES_CNT_W:0]    occupancy;
  llcb_result_t          s1_res, q_out;
  logic [8:0]            count_ext;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s,
                                                 input logic [SLOT_W-1:0] top);
    logic [SLOT_W-1:0] r;
    r = (s == top) ? '0 : s + 1'b1;
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] byte_addr(input logic [SLOT_W-1:0] s,
                                                  input logic [POS_W-1:0]  p);
    logic [ADDR_W-1:0] a;
    a = ADDR_W'(s) * LB_A + ADDR_W'(p);
    return a;
  endfunction

  // Accept while the result queue can hold every read in flight
  assign occupancy = {1'b0, q_count} + (RES_CNT_W + 1)'(s1_v_r);
  assign in_tready = (occupancy < (RES_CNT_W + 1)'(RES_DEPTH));
  assign accept    = in_tvalid && in_tready;
  assign op        = llcb_op_t'(in_tuser[0]);

  // Highest slot index of the ring, line_count clamped to MAX_LINES
  assign count_ext = 9'(line_count_r);
  assign last_idx  = (count_ext > 9'(MAX_LINES)) ? SLOT_W'(MAX_LINES) : SLOT_W'(count_ext);

  // Main update: take a configuration write, or write a byte, or commit and read one byte
  always_comb begin
    line_count_nxt = line_count_r;
    oldest_nxt     = oldest_r;
    fill_nxt       = fill_r;
    fill_pos_nxt   = fill_pos_r;
    read_pos_nxt   = read_pos_r;
    skip_nxt       = skip_r;
    cut_nxt        = cut_r;
    s1_v_nxt       = 1'b0;
    s1_valid_nxt   = 1'b0;
    s1_last_nxt    = 1'b0;
    s1_trunc_nxt   = cut_r;
    do_commit      = 1'b0;
    commit_len     = fill_pos_r;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_waddr      = byte_addr(fill_r, fill_pos_r);
    ram_wdata      = in_tdata;
    ram_raddr      = '0;
    oldest_c       = oldest_r;
    fill_c         = fill_r;
    rpos_c         = read_pos_r;
    cur_len        = '0;
    rpos_inc       = '0;

    if (cfg_wr_en) begin
      // Take new line_count and empty the ring
      line_count_nxt = cfg_wr_data;
      oldest_nxt     = '0;
      fill_nxt       = '0;
      fill_pos_nxt   = '0;
      read_pos_nxt   = '0;
      skip_nxt       = 1'b0;
    end else if (accept) begin
      // Decide whether a line closes this cycle
      if (op == OP_WRITE) begin
        if (skip_r) begin
          if (in_tdata == NEWLINE_CHAR) begin
            skip_nxt = 1'b0;
          end
        end else begin
          ram_we       = 1'b1;
          fill_pos_nxt = fill_pos_r + 1'b1;
          commit_len   = fill_pos_r + 1'b1;
          if (in_tdata == NEWLINE_CHAR) begin
            do_commit = 1'b1;
          end else if (fill_pos_r == CUT_POS) begin
            ram_wdata = NEWLINE_CHAR;
            do_commit = 1'b1;
            cut_nxt   = 1'b1;
            skip_nxt  = 1'b1;
          end
        end
      end else begin
        do_commit = (fill_pos_r != '0);
      end

      // Close the line in the fill slot, evicting the oldest when full
      if (do_commit) begin
        fill_c = slot_inc(fill_r, last_idx);
        if (fill_c == oldest_r) begin
          oldest_c = slot_inc(oldest_r, last_idx);
          rpos_c   = '0;
        end
        fill_nxt     = fill_c;
        oldest_nxt   = oldest_c;
        read_pos_nxt = rpos_c;
        fill_pos_nxt = '0;
      end

      // Read one kept byte
      if (op == OP_READ) begin
        s1_v_nxt = 1'b1;
        if (oldest_c != fill_c) begin
          cur_len      = (do_commit && oldest_c == fill_r) ? commit_len : len_r[oldest_c];
          ram_re       = 1'b1;
          ram_raddr    = byte_addr(oldest_c, rpos_c);
          s1_valid_nxt = 1'b1;
          rpos_inc     = {1'b0, rpos_c} + 1'b1;
          if (rpos_inc >= {1'b0, cur_len}) begin
            oldest_nxt   = slot_inc(oldest_c, last_idx);
            read_pos_nxt = '0;
          end else begin
            read_pos_nxt = rpos_inc[POS_W-1:0];
          end
          s1_last_nxt = (oldest_nxt == fill_c);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_count_r <= LINE_COUNT_RST;
      oldest_r     <= '0;
      fill_r       <= '0;
      fill_pos_r   <= '0;
      read_pos_r   <= '0;
      skip_r       <= 1'b0;
      cut_r        <= 1'b0;
      s1_v_r       <= 1'b0;
    end else begin
      line_count_r <= line_count_nxt;
      oldest_r     <= oldest_nxt;
      fill_r       <= fill_nxt;
      fill_pos_r   <= fill_pos_nxt;
      read_pos_r   <= read_pos_nxt;
      skip_r       <= skip_nxt;
      cut_r        <= cut_nxt;
      s1_v_r       <= s1_v_nxt;
    end
  end

  // Hold read-stage flags beside the RAM read
  always_ff @(posedge clk) begin
    s1_valid_r <= s1_valid_nxt;
    s1_last_r  <= s1_last_nxt;
    s1_trunc_r <= s1_trunc_nxt;
  end

  // Record the length of each closed line
  always_ff @(posedge clk) begin
    if (do_commit) begin
      len_r[fill_r] <= commit_len;
    end
  end

  llcb_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Form the result; a drained read returns a zero byte
  always_comb begin
    s1_res.data  = s1_valid_r ? ram_rdata : 8'd0;
    s1_res.valid = s1_valid_r;
    s1_res.last  = s1_last_r;
    s1_res.trunc = s1_trunc_r;
  end

  llcb_out_fifo u_out_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (s1_v_r),
    .push_data  (s1_res),
    .count      (q_count),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_data   (q_out)
  );

  assign out_tdata = q_out.data;
  assign out_tuser = {q_out.trunc, q_out.valid};
  assign out_tlast = q_out.last;

endmodule
